FILE: sv/fwt_pkg.sv
// Package for the futex wait table: request and status codes, the slot
// command type and the timeout rounding constants.
// No dependencies.
package fwt_pkg;

  // Request codes
  typedef enum logic [2:0] {
    REQ_WAIT        = 3'd0,
    REQ_WAIT_BITSET = 3'd1,
    REQ_WAKE        = 3'd2,
    REQ_WAKE_BITSET = 3'd3,
    REQ_REQUEUE     = 3'd4,
    REQ_CMP_REQUEUE = 3'd5,
    REQ_LEAVE       = 3'd6,
    REQ_UNKNOWN     = 3'd7
  } req_code_t;

  // Status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_QUEUED   = 4'd1;
  localparam logic [3:0] ST_INVALID  = 4'd2;
  localparam logic [3:0] ST_FAULT    = 4'd3;
  localparam logic [3:0] ST_AGAIN    = 4'd4;
  localparam logic [3:0] ST_INTR     = 4'd5;
  localparam logic [3:0] ST_NOMEM    = 4'd6;
  localparam logic [3:0] ST_TIMEDOUT = 4'd7;
  localparam logic [3:0] ST_NOSYS    = 4'd8;

  // Timeout constants
  localparam logic [31:0] NSEC_LIMIT  = 32'd1000000000;
  localparam logic [31:0] NSEC_ROUND  = 32'd999999;
  localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
  // floor(y / 15625) = (y * DIV_MUL) >> DIV_SHIFT for y below 2^24
  localparam logic [24:0] DIV_MUL     = 25'd17592187;
  localparam int          DIV_SHIFT   = 38;
  localparam logic [30:0] REQUEUE_ALL = 31'h7fffffff;

  // Slot commands
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_QUEUE   = 3'd2,
    OP_RELEASE = 3'd3,
    OP_LEAVE   = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [7:0]  space;
    logic [31:0] addr;
  } cell_cmd_t;

endpackage

FILE: sv/fwt_if.sv
// Valid/ready channel interfaces for futex table requests and responses.
// No dependencies.
interface fwt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  space_id;
  logic [31:0] word_addr;
  logic [31:0] expected;
  logic [31:0] current_word;
  logic        access_fault;
  logic signed [31:0] wake_limit;
  logic        has_timeout;
  logic [31:0] timeout_sec;
  logic [31:0] timeout_nsec;
  logic        sig_pending;
  logic        timed_out;

  modport source (output valid, req_type, space_id, word_addr, expected, current_word,
                  access_fault, wake_limit, has_timeout, timeout_sec, timeout_nsec,
                  sig_pending, timed_out, input ready);
  modport sink (input valid, req_type, space_id, word_addr, expected, current_word,
                access_fault, wake_limit, has_timeout, timeout_sec, timeout_nsec,
                sig_pending, timed_out, output ready);
endinterface

interface fwt_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  woken_count;
  logic [31:0] timeout_ms;
  logic [4:0]  slot_index;

  modport source (output valid, status, woken_count, timeout_ms, slot_index, input ready);
  modport sink (input valid, status, woken_count, timeout_ms, slot_index, output ready);
endinterface

FILE: sv/fwt_cell.sv
// One slot of the futex table: owner, address and waiter/sleeper counts.
// Depends on fwt_pkg; cells chain their hit and free flags.
module fwt_cell #(
  parameter int CNT_W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  fwt_pkg::cell_cmd_t cmd,
  input  logic               sel,
  input  logic [CNT_W-1:0]   rel_n,
  input  logic               hit_in,
  input  logic               free_in,
  output logic               hit_out,
  output logic               free_out,
  output logic               first_hit,
  output logic               first_free,
  output logic [CNT_W-1:0]   waiters,
  output logic [CNT_W-1:0]   sleepers
);
  import fwt_pkg::*;

  logic [7:0]       space;
  logic [31:0]      addr;
  logic [CNT_W-1:0] waiters_dec;
  logic             match;
  logic             is_free;

  // Compare against the request and pass the chain on
  assign is_free    = (waiters == '0);
  assign match      = !is_free && (space == cmd.space) && (addr == cmd.addr);
  assign first_hit  = match && !hit_in;
  assign first_free = is_free && !free_in;
  assign hit_out    = hit_in || match;
  assign free_out   = free_in || is_free;
  assign waiters_dec = waiters - CNT_W'(1);

  // Owner fields: written on allocation only
  always_ff @(posedge clk) begin
    if (sel && cmd.op == OP_ALLOC) begin
      space <= cmd.space;
      addr  <= cmd.addr;
    end
  end

  // Apply the slot command
  always_ff @(posedge clk) begin
    if (rst) begin
      waiters  <= '0;
      sleepers <= '0;
    end else if (sel) begin
      unique case (cmd.op)
        OP_ALLOC: begin
          waiters  <= CNT_W'(1);
          sleepers <= CNT_W'(1);
        end
        OP_QUEUE: begin
          waiters  <= waiters + CNT_W'(1);
          sleepers <= sleepers + CNT_W'(1);
        end
        OP_RELEASE: sleepers <= sleepers - rel_n;
        OP_LEAVE: begin
          waiters <= waiters_dec;
          if (sleepers > waiters_dec) sleepers <= waiters_dec;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/futex_wait_table.sv
// Futex wait table: a request passes the accept, slot lookup along the chain of
// ENTRIES cells with timeout rounding, then decision and slot update steps; the
// decision waits while the response register holds a response not yet taken. One request is in
// flight at a time; the next is accepted once the previous one has been decided.
module futex_wait_table #(
  parameter int ENTRIES     = 32,
  parameter int MAX_WAITERS = 255
) (
  input logic    clk,
  input logic    rst,
  fwt_req_if.sink   req,
  fwt_rsp_if.source rsp
);
  import fwt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_WAITERS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state, state_next;

  // Latched request
  logic [2:0]  r_type;
  logic [7:0]  r_space;
  logic [31:0] r_addr, r_expected, r_current, r_sec, r_nsec;
  logic        r_fault, r_has_to, r_sig, r_timed_out;
  logic signed [31:0] r_limit;

  // Lookup results
  logic             hit, free_found;
  logic [IDX_W-1:0] hit_idx, free_idx;
  logic [CNT_W-1:0] hit_w, hit_s;
  logic [48:0]      div_prod;
  logic [31:0]      sec_ms;

  // Cell chain
  logic [ENTRIES:0]   hit_chain, free_chain;
  logic [ENTRIES-1:0] first_hit, first_free, sel;
  logic [CNT_W-1:0]   cell_w [ENTRIES];
  logic [CNT_W-1:0]   cell_s [ENTRIES];
  cell_cmd_t          cmd;
  cell_op_t           cmd_op;
  logic [CNT_W-1:0]   rel_n;
  logic [IDX_W-1:0]   tgt;

  // Decision
  logic [3:0]  d_status;
  logic [7:0]  d_woken;
  logic [31:0] d_ms;
  logic [IDX_W-1:0] d_idx;

  logic        out_valid;
  logic        advance;
  logic        accept;

  assign accept  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign advance = (state == S_EXEC) && (!out_valid || rsp.ready);

  // Sequence the request
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid) state_next = S_LOOK;
      S_LOOK: state_next = S_EXEC;
      S_EXEC: if (advance) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      r_type      <= req.req_type;
      r_space     <= req.space_id;
      r_addr      <= req.word_addr;
      r_expected  <= req.expected;
      r_current   <= req.current_word;
      r_fault     <= req.access_fault;
      r_limit     <= req.wake_limit;
      r_has_to    <= req.has_timeout;
      r_sec       <= req.timeout_sec;
      r_nsec      <= req.timeout_nsec;
      r_sig       <= req.sig_pending;
      r_timed_out <= req.timed_out;
    end
  end

  // Build the chain of slots
  assign hit_chain[0]  = 1'b0;
  assign free_chain[0] = 1'b0;
  assign cmd = '{op: cmd_op, space: r_space, addr: r_addr};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign sel[i] = (cmd.op != OP_NONE) && (tgt == IDX_W'(i));
    fwt_cell #(.CNT_W(CNT_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .sel        (sel[i]),
      .rel_n      (rel_n),
      .hit_in     (hit_chain[i]),
      .free_in    (free_chain[i]),
      .hit_out    (hit_chain[i+1]),
      .free_out   (free_chain[i+1]),
      .first_hit  (first_hit[i]),
      .first_free (first_free[i]),
      .waiters    (cell_w[i]),
      .sleepers   (cell_s[i])
    );
  end

  // Encode the first hit and first free slot, and round the timeout
  always_ff @(posedge clk) begin
    logic [IDX_W-1:0] hi, fi;
    logic [CNT_W-1:0] hw, hs;
    logic [32:0]      ns_up;
    hi = '0; fi = '0; hw = '0; hs = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first_hit[i]) begin
        hi = hi | IDX_W'(i);
        hw = hw | cell_w[i];
        hs = hs | cell_s[i];
      end
      if (first_free[i]) fi = fi | IDX_W'(i);
    end
    ns_up = {1'b0, r_nsec} + {1'b0, NSEC_ROUND};
    if (state == S_LOOK) begin
      hit        <= hit_chain[ENTRIES];
      free_found <= free_chain[ENTRIES];
      hit_idx    <= hi;
      free_idx   <= fi;
      hit_w      <= hw;
      hit_s      <= hs;
      div_prod   <= ns_up[29:6] * DIV_MUL;
      sec_ms     <= 32'(r_sec * {22'd0, MS_PER_SEC});
    end
  end

  // Decide the response and the slot update
  always_comb begin
    logic        timed;
    logic [31:0] ms_sum;
    logic [30:0] lim;
    logic        rel;
    d_status = ST_OK;
    d_woken  = '0;
    d_ms     = '0;
    d_idx    = '0;
    cmd_op   = OP_NONE;
    tgt      = hit_idx;
    rel      = 1'b0;
    lim      = REQUEUE_ALL;
    timed    = (r_type == REQ_WAIT) && r_has_to;
    ms_sum   = sec_ms + {22'd0, div_prod[47:DIV_SHIFT]};
    if (r_type == REQ_LEAVE) begin
      if (!hit) d_status = ST_INVALID;
      else begin
        cmd_op = OP_LEAVE;
        d_idx  = hit_idx;
        if (r_timed_out) d_status = ST_TIMEDOUT;
        else if (r_sig)  d_status = ST_INTR;
      end
    end else if (r_space == 8'd0) begin
      d_status = ST_FAULT;
    end else begin
      unique case (r_type)
        REQ_WAIT, REQ_WAIT_BITSET: begin
          if (r_type == REQ_WAIT_BITSET && r_has_to) d_status = ST_NOSYS;
          else if (timed && r_nsec >= NSEC_LIMIT)    d_status = ST_INVALID;
          else if (r_addr[1:0] != 2'b00)             d_status = ST_INVALID;
          else if (r_fault)                          d_status = ST_FAULT;
          else if (r_current != r_expected)          d_status = ST_AGAIN;
          else if (r_sig)                            d_status = ST_INTR;
          else if (hit) begin
            if (32'(hit_w) >= 32'(MAX_WAITERS)) d_status = ST_NOMEM;
            else begin
              cmd_op = OP_QUEUE;
              d_status = ST_QUEUED;
              d_idx = hit_idx;
            end
          end else if (free_found) begin
            cmd_op   = OP_ALLOC;
            tgt      = free_idx;
            d_status = ST_QUEUED;
            d_idx    = free_idx;
          end else d_status = ST_NOMEM;
          if (d_status == ST_QUEUED && timed)
            d_ms = (ms_sum == 32'd0) ? 32'd1 : ms_sum;
        end
        REQ_WAKE, REQ_WAKE_BITSET: begin
          if (r_addr[1:0] != 2'b00) d_status = ST_INVALID;
          else if (r_fault)         d_status = ST_FAULT;
          else begin
            rel = 1'b1;
            lim = r_limit[31] ? 31'd0 : r_limit[30:0];
          end
        end
        REQ_REQUEUE: rel = 1'b1;
        REQ_CMP_REQUEUE: begin
          if (r_addr[1:0] != 2'b00)         d_status = ST_INVALID;
          else if (r_fault)                 d_status = ST_FAULT;
          else if (r_current != r_expected) d_status = ST_AGAIN;
          else rel = 1'b1;
        end
        default: d_status = ST_NOSYS;
      endcase
    end
    rel_n = ({1'b0, lim} < 32'(hit_s)) ? CNT_W'(lim) : hit_s;
    if (rel && hit) begin
      cmd_op  = OP_RELEASE;
      d_woken = 8'(rel_n);
      d_idx   = hit_idx;
    end
    if (!advance) cmd_op = OP_NONE;
  end

  // Hold the response until taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= 1'b1;
    else if (rsp.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.status      <= d_status;
      rsp.woken_count <= d_woken;
      rsp.timeout_ms  <= d_ms;
      rsp.slot_index  <= 5'(d_idx);
    end
  end

  assign rsp.valid = out_valid;

  // Checks
  a_one_target: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_NONE) |-> $onehot(sel))
    else $error("slot command selects more than one slot");
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOOK))
    else $error("accepted request did not enter lookup");
  a_look_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |=> (state == S_EXEC))
    else $error("lookup did not proceed to decision");
  a_update_only_exec: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_NONE) |-> (state == S_EXEC) && advance)
    else $error("slot update outside decision");

endmodule
